FILE: src/tbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types and constants for the triangle barycentric coverage block.
// ----------------------------------------------------------------------------
package tbc_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PIXEL_BITS = 12;
    localparam int COEF_FRAC  = 32;
    localparam int VTX_W      = 32;
    localparam int SCALE_W    = 32;
    localparam int STATE_W    = 48;
    localparam int EDGE_W     = STATE_W + 1;
    localparam int MAG_W      = STATE_W;
    localparam int CHUNK_W    = MAG_W / 2;
    localparam int PP_W       = MAG_W + CHUNK_W;
    localparam int ACC_W      = 100;
    localparam int PROD_W     = VTX_W + SCALE_W;
    localparam int UNIT_SHIFT = SCALE_W - FRAC_BITS;
    localparam int DIV_W      = 2 * MAG_W + 1;
    localparam int NUM_SHIFT  = FRAC_BITS + COEF_FRAC;
    localparam int QUO_W      = STATE_W;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int WSHIFT     = COEF_FRAC + FRAC_BITS - 16;
    localparam int WCAP_W     = 41;
    localparam int WT_W       = WCAP_W + 1;
    localparam int WC_W       = WT_W + 2;
    localparam int OUT_WT_W   = 17;

    localparam logic [SCALE_W-1:0]  SCALE_RESET = 32'd65536;
    localparam logic [WC_W-1:0]     ONE_Q16     = 44'd65536;
    localparam logic [WCAP_W-1:0]   WEIGHT_CAP  = 41'h100_0000_0000;
    localparam logic [QUO_W-1:0]    COEF_MAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX   = 12'hFFF;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;
    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    typedef struct packed {
        logic                     action;
        logic signed [VTX_W-1:0]  vertex_a_x;
        logic signed [VTX_W-1:0]  vertex_a_y;
        logic signed [VTX_W-1:0]  vertex_b_x;
        logic signed [VTX_W-1:0]  vertex_b_y;
        logic signed [VTX_W-1:0]  vertex_c_x;
        logic signed [VTX_W-1:0]  vertex_c_y;
        logic [PIXEL_BITS-1:0]    pixel_x;
        logic [PIXEL_BITS-1:0]    pixel_y;
    } t_in_item;

    typedef struct packed {
        logic                     result_kind;
        logic [PIXEL_BITS-1:0]    box_min_x;
        logic [PIXEL_BITS-1:0]    box_min_y;
        logic [PIXEL_BITS-1:0]    box_max_x;
        logic [PIXEL_BITS-1:0]    box_max_y;
        logic                     covered;
        logic [OUT_WT_W-1:0]      weight_a;
        logic [OUT_WT_W-1:0]      weight_b;
        logic [OUT_WT_W-1:0]      weight_c;
        logic                     flat;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_WAIT,
        S_MUL_CAP,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_CAP,
        S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        ST_UNIT_AX,
        ST_UNIT_AY,
        ST_UNIT_BX,
        ST_UNIT_BY,
        ST_UNIT_CX,
        ST_UNIT_CY,
        ST_DET_POS,
        ST_DET_NEG,
        ST_WA_X,
        ST_WA_Y,
        ST_WB_X,
        ST_WB_Y
    } t_step;

    typedef struct packed {
        logic       accept;
        logic       mul_lo;
        logic       mul_hi;
        logic       cap;
        logic       div_init;
        logic       div_step;
        logic       div_cap;
        logic       load_out;
        t_step      step;
        logic [1:0] div_idx;
    } t_cmd;

    typedef struct packed {
        logic flat;
        logic acc_zero;
    } t_status;

endpackage

FILE: src/tbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_ctrl
// Sequencer: steps the shared multiplier, the divider and the output handoff.
// ----------------------------------------------------------------------------
module tbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_action,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  tbc_pkg::t_status i_status,
    output tbc_pkg::t_cmd    o_cmd
);
    import tbc_pkg::*;

    t_state            r_state, n_state;
    t_step             r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]        r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_UNIT_AX;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.step    = r_step;
        o_cmd.div_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_action == ACT_QUERY) begin
                        // a flat triangle answers without any arithmetic
                        n_state = i_status.flat ? S_FINISH : S_MUL_LO;
                        n_step  = ST_WA_X;
                    end else begin
                        n_state = S_MUL_LO;
                        n_step  = ST_UNIT_AX;
                    end
                end
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                if (r_step == ST_DET_POS || r_step == ST_WA_X || r_step == ST_WB_X) begin
                    n_step  = t_step'(r_step + 4'd1);
                    n_state = S_MUL_LO;
                end else begin
                    n_state = S_MUL_WAIT;
                end
            end
            S_MUL_WAIT: begin
                n_state = S_MUL_CAP;
            end
            S_MUL_CAP: begin
                o_cmd.cap = 1'b1;
                if (r_step == ST_DET_NEG) begin
                    n_idx   = '0;
                    n_state = i_status.acc_zero ? S_FINISH : S_DIV_INIT;
                end else if (r_step == ST_WB_Y) begin
                    n_state = S_FINISH;
                end else begin
                    n_step  = t_step'(r_step + 4'd1);
                    n_state = S_MUL_LO;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = S_DIV_CAP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIV_CAP: begin
                o_cmd.div_cap = 1'b1;
                if (r_idx == 2'd3) begin
                    n_state = S_FINISH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DIV_INIT;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/tbc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_dp
// Datapath: shared 48x24 multiplier with accumulator, restoring divider,
// triangle state and the output register.
// ----------------------------------------------------------------------------
module tbc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbc_pkg::t_in_item  i_in_data,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    input  tbc_pkg::t_cmd      i_cmd,
    output tbc_pkg::t_status   o_status,
    output tbc_pkg::t_out_item o_out_data
);
    import tbc_pkg::*;

    t_in_item                 r_item;
    logic [SCALE_W-1:0]       r_scale;
    logic signed [STATE_W-1:0] r_unit [6];
    logic [PIXEL_BITS-1:0]    r_box [6];
    logic signed [STATE_W-1:0] r_anchor_x, r_anchor_y;
    logic signed [STATE_W-1:0] r_coef [4];
    logic                     r_flat;
    logic [PP_W-1:0]          r_pp;
    logic                     r_pp_valid, r_pp_neg, r_pp_hi, r_pp_clr;
    logic [ACC_W-1:0]         r_acc;
    logic [DIV_W-1:0]         r_dm;
    logic                     r_det_neg;
    logic [DIV_W-1:0]         r_rem;
    logic [MAG_W-1:0]         r_nlow;
    logic [QUO_W-1:0]         r_q;
    logic                     r_ovf, r_dneg;
    logic signed [WT_W-1:0]   r_wa, r_wb;
    t_out_item                r_out;

    logic signed [EDGE_W-1:0] edge_v [4];
    logic signed [EDGE_W-1:0] dx, dy, op_a, op_b;
    logic                     op_flip, mul_neg;
    logic [MAG_W-1:0]         a_mag, b_mag;
    logic [CHUNK_W-1:0]       b_chunk;
    logic [ACC_W-1:0]         pp_ext, pp_term, acc_base;
    logic                     acc_zero;
    logic [PROD_W-1:0]        prod;
    logic [PIXEL_BITS-1:0]    box_val;
    logic signed [WT_W-1:0]   w_now;
    logic [ACC_W-1:0]         w_mag, w_sum;
    logic [ACC_W-WSHIFT-1:0]  w_m;
    logic [WCAP_W-1:0]        w_sat;
    logic signed [EDGE_W-1:0] div_e;
    logic [MAG_W-1:0]         div_em;
    logic [DIV_W-1:0]         div_n;
    logic [DIV_W:0]           div_t;
    logic                     div_ge;
    logic [QUO_W-1:0]         q_mag;
    logic signed [WC_W-1:0]   wc;
    logic                     covered;
    logic [PIXEL_BITS-1:0]    bmin_x, bmin_y, bmax_x, bmax_y;
    t_out_item                out_next;

    function automatic logic signed [EDGE_W-1:0] sub_s(
        input logic signed [STATE_W-1:0] a,
        input logic signed [STATE_W-1:0] b
    );
        return EDGE_W'(a) - EDGE_W'(b);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] min3(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input logic [PIXEL_BITS-1:0] c
    );
        logic [PIXEL_BITS-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [PIXEL_BITS-1:0] max3(
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b,
        input logic [PIXEL_BITS-1:0] c
    );
        logic [PIXEL_BITS-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // edge terms: yb-yc, xc-xb, yc-ya, xa-xc
    assign edge_v[0] = sub_s(r_unit[3], r_unit[5]);
    assign edge_v[1] = sub_s(r_unit[4], r_unit[2]);
    assign edge_v[2] = sub_s(r_unit[5], r_unit[1]);
    assign edge_v[3] = sub_s(r_unit[0], r_unit[4]);

    assign dx = EDGE_W'({r_item.pixel_x, {FRAC_BITS{1'b0}}}) - EDGE_W'(r_anchor_x);
    assign dy = EDGE_W'({r_item.pixel_y, {FRAC_BITS{1'b0}}}) - EDGE_W'(r_anchor_y);

    always_comb begin
        op_a    = '0;
        op_b    = EDGE_W'(r_scale);
        op_flip = 1'b0;
        unique case (i_cmd.step)
            ST_UNIT_AX: op_a = EDGE_W'(r_item.vertex_a_x);
            ST_UNIT_AY: op_a = EDGE_W'(r_item.vertex_a_y);
            ST_UNIT_BX: op_a = EDGE_W'(r_item.vertex_b_x);
            ST_UNIT_BY: op_a = EDGE_W'(r_item.vertex_b_y);
            ST_UNIT_CX: op_a = EDGE_W'(r_item.vertex_c_x);
            ST_UNIT_CY: op_a = EDGE_W'(r_item.vertex_c_y);
            ST_DET_POS: begin
                op_a = edge_v[0];
                op_b = edge_v[3];
            end
            ST_DET_NEG: begin
                op_a    = edge_v[1];
                op_b    = edge_v[2];
                op_flip = 1'b1;
            end
            ST_WA_X: begin
                op_a = EDGE_W'(r_coef[0]);
                op_b = dx;
            end
            ST_WA_Y: begin
                op_a = EDGE_W'(r_coef[1]);
                op_b = dy;
            end
            ST_WB_X: begin
                op_a = EDGE_W'(r_coef[2]);
                op_b = dx;
            end
            ST_WB_Y: begin
                op_a = EDGE_W'(r_coef[3]);
                op_b = dy;
            end
            default: op_a = '0;
        endcase
    end

    assign a_mag   = op_a[EDGE_W-1] ? MAG_W'(-op_a) : op_a[MAG_W-1:0];
    assign b_mag   = op_b[EDGE_W-1] ? MAG_W'(-op_b) : op_b[MAG_W-1:0];
    assign mul_neg = op_a[EDGE_W-1] ^ op_b[EDGE_W-1] ^ op_flip;
    assign b_chunk = i_cmd.mul_hi ? b_mag[MAG_W-1:CHUNK_W] : b_mag[CHUNK_W-1:0];

    assign pp_ext   = r_pp_hi ? (ACC_W'(r_pp) << CHUNK_W) : ACC_W'(r_pp);
    assign pp_term  = r_pp_neg ? (~pp_ext + 1'b1) : pp_ext;
    assign acc_base = r_pp_clr ? '0 : r_acc;
    assign acc_zero = (r_acc == '0);

    // unit conversion and box of one scaled vertex
    assign prod = r_acc[PROD_W-1:0];
    always_comb begin
        if (prod[PROD_W-1] || prod == '0) begin
            box_val = '0;
        end else if (prod[PROD_W-1:SCALE_W] > SCALE_W'(PIX_MAX)) begin
            box_val = PIX_MAX;
        end else begin
            box_val = prod[SCALE_W+PIXEL_BITS-1:SCALE_W];
        end
    end

    // weight rounding: half away from zero, then saturate
    assign w_mag = r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign w_sum = w_mag + (ACC_W'(1) << (WSHIFT - 1));
    assign w_m   = w_sum[ACC_W-1:WSHIFT];
    assign w_sat = (w_m > (ACC_W-WSHIFT)'(WEIGHT_CAP)) ? WEIGHT_CAP : w_m[WCAP_W-1:0];
    assign w_now = r_acc[ACC_W-1] ? -$signed({1'b0, w_sat}) : $signed({1'b0, w_sat});

    // divider: rounded numerator, remainder kept below the divisor unless it overflows
    assign div_e  = edge_v[i_cmd.div_idx];
    assign div_em = div_e[EDGE_W-1] ? MAG_W'(-div_e) : div_e[MAG_W-1:0];
    assign div_n  = DIV_W'({div_em, {NUM_SHIFT{1'b0}}}) + (r_dm >> 1);
    assign div_t  = {r_rem, r_nlow[MAG_W-1]};
    assign div_ge = (div_t >= {1'b0, r_dm});
    assign q_mag  = (r_ovf || r_q[QUO_W-1]) ? COEF_MAX : r_q;

    assign wc = ONE_Q16 - WC_W'(r_wa) - WC_W'(r_wb);
    assign covered = !r_flat && !r_wa[WT_W-1] && !r_wb[WT_W-1] && !wc[WC_W-1];
    assign bmin_x = min3(r_box[0], r_box[2], r_box[4]);
    assign bmin_y = min3(r_box[1], r_box[3], r_box[5]);
    assign bmax_x = max3(r_box[0], r_box[2], r_box[4]);
    assign bmax_y = max3(r_box[1], r_box[3], r_box[5]);

    always_comb begin
        out_next      = '0;
        out_next.flat = r_flat;
        if (r_item.action == ACT_QUERY) begin
            out_next.result_kind = KIND_WEIGHT;
            out_next.covered     = covered;
            if (covered) begin
                out_next.weight_a = r_wa[OUT_WT_W-1:0];
                out_next.weight_b = r_wb[OUT_WT_W-1:0];
                out_next.weight_c = wc[OUT_WT_W-1:0];
            end
        end else begin
            out_next.result_kind = KIND_BOX;
            out_next.box_min_x   = bmin_x;
            out_next.box_min_y   = bmin_y;
            out_next.box_max_x   = bmax_x;
            out_next.box_max_y   = bmax_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= SCALE_RESET;
            r_anchor_x <= '0;
            r_anchor_y <= '0;
            r_coef     <= '{default: '0};
            r_flat     <= 1'b1;
            r_pp_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_scale <= i_cfg_data;
            end
            r_pp_valid <= i_cmd.mul_lo || i_cmd.mul_hi;
            if (i_cmd.cap && i_cmd.step == ST_DET_NEG) begin
                r_anchor_x <= r_unit[4];
                r_anchor_y <= r_unit[5];
                r_flat     <= acc_zero;
                if (acc_zero) begin
                    r_coef <= '{default: '0};
                end
            end
            if (i_cmd.div_cap) begin
                r_coef[i_cmd.div_idx] <= r_dneg ? -$signed(q_mag) : $signed(q_mag);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.mul_lo || i_cmd.mul_hi) begin
            r_pp     <= a_mag * b_chunk;
            r_pp_neg <= mul_neg;
            r_pp_hi  <= i_cmd.mul_hi;
            r_pp_clr <= i_cmd.mul_lo && i_cmd.step != ST_DET_NEG
                        && i_cmd.step != ST_WA_Y && i_cmd.step != ST_WB_Y;
        end
        if (r_pp_valid) begin
            r_acc <= acc_base + pp_term;
        end
        if (i_cmd.cap) begin
            unique case (i_cmd.step)
                ST_UNIT_AX, ST_UNIT_AY, ST_UNIT_BX, ST_UNIT_BY, ST_UNIT_CX, ST_UNIT_CY: begin
                    r_unit[3'(i_cmd.step)] <= prod[UNIT_SHIFT+STATE_W-1:UNIT_SHIFT];
                    r_box[3'(i_cmd.step)]  <= box_val;
                end
                ST_DET_NEG: begin
                    r_dm      <= r_acc[ACC_W-1] ? DIV_W'(~r_acc + 1'b1) : r_acc[DIV_W-1:0];
                    r_det_neg <= r_acc[ACC_W-1];
                end
                ST_WA_Y: r_wa <= w_now;
                ST_WB_Y: r_wb <= w_now;
                default: r_wa <= r_wa;
            endcase
        end
        if (i_cmd.div_init) begin
            r_rem  <= DIV_W'(div_n[DIV_W-1:QUO_W]);
            r_ovf  <= (DIV_W'(div_n[DIV_W-1:QUO_W]) >= r_dm);
            r_nlow <= div_n[MAG_W-1:0];
            r_q    <= '0;
            r_dneg <= div_e[EDGE_W-1] ^ r_det_neg;
        end
        if (i_cmd.div_step) begin
            r_rem  <= div_ge ? DIV_W'(div_t - {1'b0, r_dm}) : div_t[DIV_W-1:0];
            r_q    <= {r_q[QUO_W-2:0], div_ge};
            r_nlow <= r_nlow << 1;
        end
        if (i_cmd.load_out) begin
            r_out <= out_next;
        end
    end

    assign o_status.flat     = r_flat;
    assign o_status.acc_zero = acc_zero;
    assign o_out_data        = r_out;

endmodule

FILE: src/triangle_barycentric_coverage_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_barycentric_coverage_top
// Triangle load (bounding box, barycentric coefficients) and pixel queries.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  input     i_in_valid, i_in_data, o_in_stall    request in
//  output    o_out_valid, o_out_data, i_out_stall request out
//  config    i_cfg_valid, i_cfg_data, o_cfg_ready pixel_scale write
//
// a query forms its weights on the shared 48x24 multiplier;
// a flat query answers without any arithmetic
// a load forms 8 products, then four divisions (products only when flat);
// each result is valid in the same cycle the block is ready for a new request
// the output register holds a stalled result while the next request works,
// and a finished request waits until that register is free
// reset is synchronous, active low; no clearing pass is needed
// ----------------------------------------------------------------------------
module triangle_barycentric_coverage_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tbc_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output tbc_pkg::t_out_item o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_valid,
    input  logic [31:0]        i_cfg_data,
    output logic               o_cfg_ready
);
    import tbc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    tbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tbc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: src/tbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_checker
// Port-level checks for the triangle barycentric coverage block.
// ----------------------------------------------------------------------------
module tbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input tbc_pkg::t_in_item  i_in_data,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input tbc_pkg::t_out_item o_out_data,
    input logic               i_out_stall
);
    import tbc_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    // no request is accepted back to back: every accept is followed by a stall
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted back to back");

    a_box_no_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_BOX |->
        !o_out_data.covered && o_out_data.weight_a == '0
        && o_out_data.weight_b == '0 && o_out_data.weight_c == '0)
        else $error("box result carries weights");

    a_flat_uncovered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.flat |-> !o_out_data.covered)
        else $error("flat triangle reported covered");

endmodule

bind triangle_barycentric_coverage_top tbc_checker u_tbc_checker (.*);
